/* hdl/lobm_pkg.sv */
package lobm_pkg;

	localparam int SYM_W      = 3;
	localparam int TRADER_W   = 10;
	localparam int PRICE_W    = 20;
	localparam int QTY_W      = 16;
	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 56;
	localparam int MAX_FILLS  = 31;
	localparam int FILL_CNT_W = 5;

	typedef enum logic [1:0] {
		REQ_ADD,
		REQ_CHANGE,
		REQ_CANCEL,
		REQ_MATCH
	} req_t;

	typedef enum logic [2:0] {
		STAT_DONE,
		STAT_FULL,
		STAT_NOT_FOUND,
		STAT_REJECTED,
		STAT_FILL
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DISPATCH,
		S_ADD_RD,
		S_ADD_WR,
		S_ADD_HEAD,
		S_FIND_RD,
		S_FIND_CK,
		S_DEL_RD,
		S_DEL_WR,
		S_RESP,
		S_M_TEST,
		S_M_RDB,
		S_M_RDS,
		S_M_CK,
		S_M_FILL,
		S_M_UPB,
		S_M_UPS,
		S_M_FIN
	} fsm_t;

endpackage

/* hdl/limit_order_book_matcher.sv */
// limit order book with price priority matching, one book per symbol.
// s_* channel: one request per beat, kind in s_tuser. m_* channel: result beats,
// status in m_tuser, m_tlast on the final beat of each request.
// one request is handled at a time; s_tready is high only while the sequencer is idle.
// all orders sit in one single-port-write, registered-read memory, one entry per slot;
// every step through it is an address, then registered data.
// add: walks down from the tail of the side, n orders on that side, while shifting
// entries up. change/cancel: search from the head; a cancel then moves the later
// entries down. match: each fill reads both heads, and a head order that is removed
// shifts the entries of its side down; at most 31 fills per request.
// a fill is held back one step so that its last flag is known before it is sent.
// the result register lets the next request in while the last result still waits;
// a stalled receiver holds the sequencer only when a further result must be sent.
// reset clears the per-side order counts at once; the order memory is not cleared,
// entries above a side's count are never read.
module limit_order_book_matcher #(
	parameter int NUM_SYMBOLS = 8,
	parameter int DEPTH       = 16,
	parameter int PRICE_BITS  = 20,
	parameter int QTY_BITS    = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// symbol, is_buy, trader_id, price, quantity, new_quantity
	input  logic [lobm_pkg::IN_DATA_W-1:0]  s_tdata,
	// req_type
	input  logic [1:0]                      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// buyer_id, seller_id, trade_price, trade_quantity
	output logic [lobm_pkg::OUT_DATA_W-1:0] m_tdata,
	// status
	output logic [2:0]                      m_tuser,
	output logic                            m_tlast
);

	localparam int ENTRIES = NUM_SYMBOLS * 2 * DEPTH;
	localparam int AW      = $clog2(ENTRIES);
	localparam int CW      = $clog2(DEPTH + 1);
	localparam int CNT_N   = NUM_SYMBOLS * 2;
	localparam int CIW     = $clog2(CNT_N);
	localparam int TW      = lobm_pkg::TRADER_W;
	localparam int EW      = TW + PRICE_BITS + QTY_BITS;

	function automatic logic [AW-1:0] addr_of(input logic [lobm_pkg::SYM_W-1:0] sym,
		input logic sd, input int slot);
		addr_of = AW'((int'(sym) * 2 + int'(sd)) * DEPTH + slot);
	endfunction

	function automatic logic [CIW-1:0] ci_of(input logic [lobm_pkg::SYM_W-1:0] sym,
		input logic sd);
		ci_of = CIW'(int'(sym) * 2 + int'(sd));
	endfunction

	lobm_pkg::fsm_t    state_q, state_d, dret_q;
	lobm_pkg::req_t    req_q;
	lobm_pkg::status_t res_status_q;

	logic [lobm_pkg::SYM_W-1:0]   sym_q;
	logic                         side_q, dside_q;
	logic [TW-1:0]                trader_q;
	logic [lobm_pkg::PRICE_W-1:0] price_q;
	logic [lobm_pkg::QTY_W-1:0]   qty_q, nqty_q;
	logic [CW-1:0]                cnt_q [CNT_N];
	logic [CW-1:0]                j_q;
	logic [EW-1:0]                bh_q, sh_q, rdata_q;
	logic [EW-1:0]                mem [ENTRIES];
	logic                         pend_v_q;
	logic [lobm_pkg::OUT_DATA_W-1:0] pend_q;
	logic [lobm_pkg::FILL_CNT_W-1:0] fills_q;

	logic                         m_tvalid_q, m_tlast_q;
	logic [lobm_pkg::OUT_DATA_W-1:0] m_tdata_q;
	logic [2:0]                   m_tuser_q;

	logic                         mem_we;
	logic [AW-1:0]                mem_waddr, mem_raddr;
	logic [EW-1:0]                mem_wdata;
	logic                         out_load, out_last;
	logic [lobm_pkg::OUT_DATA_W-1:0] out_data;
	lobm_pkg::status_t            out_status;

	logic [CW-1:0]                n_req, n_del, nb, ns;
	logic [TW-1:0]                e_trader;
	logic [PRICE_BITS-1:0]        e_price, bp, sp;
	logic [QTY_BITS-1:0]          e_qty, bq, sq, fq;
	logic [EW-1:0]                new_entry;
	logic                         sym_bad, price_bad, qty_bad, nqty_bad;
	logic                         stays, hit, crossed, out_free;
	logic                         more_find, more_del, del_go;
	logic [PRICE_BITS:0]          mid;
	logic [lobm_pkg::OUT_DATA_W-1:0] fill_word;

	always_comb begin
		n_req     = cnt_q[ci_of(sym_q, side_q)];
		n_del     = cnt_q[ci_of(sym_q, dside_q)];
		nb        = cnt_q[ci_of(sym_q, 1'b1)];
		ns        = cnt_q[ci_of(sym_q, 1'b0)];
		e_trader  = rdata_q[EW-1 -: TW];
		e_price   = rdata_q[QTY_BITS +: PRICE_BITS];
		e_qty     = rdata_q[QTY_BITS-1:0];
		bp        = bh_q[QTY_BITS +: PRICE_BITS];
		bq        = bh_q[QTY_BITS-1:0];
		sp        = sh_q[QTY_BITS +: PRICE_BITS];
		sq        = sh_q[QTY_BITS-1:0];
		fq        = (bq < sq) ? bq : sq;
		mid       = (PRICE_BITS + 1)'(({1'b0, bp} + {1'b0, sp}) >> 1);
		fill_word = {lobm_pkg::QTY_W'(fq), lobm_pkg::PRICE_W'(mid),
			sh_q[EW-1 -: TW], bh_q[EW-1 -: TW]};
		new_entry = {trader_q, PRICE_BITS'(price_q), QTY_BITS'(qty_q)};
		sym_bad   = int'(sym_q) >= NUM_SYMBOLS;
		price_bad = (32'(price_q) >> PRICE_BITS) != 32'd0;
		qty_bad   = (qty_q == '0) || ((32'(qty_q) >> QTY_BITS) != 32'd0);
		nqty_bad  = (nqty_q == '0) || ((32'(nqty_q) >> QTY_BITS) != 32'd0);
		stays     = side_q ? (32'(e_price) > 32'(price_q)) : (32'(e_price) < 32'(price_q));
		hit       = (e_trader == trader_q) && (32'(e_price) == 32'(price_q))
			&& (32'(e_qty) == 32'(qty_q));
		crossed   = 32'(bp) >= 32'(e_price);
		out_free  = !m_tvalid_q || m_tready;
		more_find = (int'(j_q) + 1) < int'(n_req);
		more_del  = (int'(j_q) + 2) < int'(n_del);
		del_go    = (int'(j_q) + 1) < int'(n_del);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lobm_pkg::S_IDLE:     if (s_tvalid) state_d = lobm_pkg::S_DISPATCH;
			lobm_pkg::S_DISPATCH: begin
				if (sym_bad) begin
					state_d = lobm_pkg::S_RESP;
				end else begin
					unique case (req_q)
						lobm_pkg::REQ_ADD: begin
							if (price_bad || qty_bad || int'(n_req) >= DEPTH || n_req == '0)
								state_d = lobm_pkg::S_RESP;
							else
								state_d = lobm_pkg::S_ADD_RD;
						end
						lobm_pkg::REQ_CHANGE: begin
							if (nqty_bad || n_req == '0) state_d = lobm_pkg::S_RESP;
							else state_d = lobm_pkg::S_FIND_RD;
						end
						lobm_pkg::REQ_CANCEL: begin
							if (n_req == '0) state_d = lobm_pkg::S_RESP;
							else state_d = lobm_pkg::S_FIND_RD;
						end
						lobm_pkg::REQ_MATCH: state_d = lobm_pkg::S_M_TEST;
						default: state_d = lobm_pkg::S_RESP;
					endcase
				end
			end
			lobm_pkg::S_ADD_RD:   state_d = lobm_pkg::S_ADD_WR;
			lobm_pkg::S_ADD_WR: begin
				if (stays) state_d = lobm_pkg::S_RESP;
				else if (j_q == '0) state_d = lobm_pkg::S_ADD_HEAD;
				else state_d = lobm_pkg::S_ADD_RD;
			end
			lobm_pkg::S_ADD_HEAD: state_d = lobm_pkg::S_RESP;
			lobm_pkg::S_FIND_RD:  state_d = lobm_pkg::S_FIND_CK;
			lobm_pkg::S_FIND_CK: begin
				if (hit) begin
					if (req_q == lobm_pkg::REQ_CANCEL && del_go) state_d = lobm_pkg::S_DEL_RD;
					else state_d = lobm_pkg::S_RESP;
				end else if (more_find) begin
					state_d = lobm_pkg::S_FIND_RD;
				end else begin
					state_d = lobm_pkg::S_RESP;
				end
			end
			lobm_pkg::S_DEL_RD:   state_d = lobm_pkg::S_DEL_WR;
			lobm_pkg::S_DEL_WR:   state_d = more_del ? lobm_pkg::S_DEL_RD : dret_q;
			lobm_pkg::S_RESP:     if (out_free) state_d = lobm_pkg::S_IDLE;
			lobm_pkg::S_M_TEST: begin
				if (int'(fills_q) >= lobm_pkg::MAX_FILLS || nb == '0 || ns == '0)
					state_d = lobm_pkg::S_M_FIN;
				else
					state_d = lobm_pkg::S_M_RDB;
			end
			lobm_pkg::S_M_RDB:    state_d = lobm_pkg::S_M_RDS;
			lobm_pkg::S_M_RDS:    state_d = lobm_pkg::S_M_CK;
			lobm_pkg::S_M_CK:     state_d = crossed ? lobm_pkg::S_M_FILL : lobm_pkg::S_M_FIN;
			lobm_pkg::S_M_FILL:   if (!pend_v_q || out_free) state_d = lobm_pkg::S_M_UPB;
			lobm_pkg::S_M_UPB: begin
				if (bq == fq && int'(nb) > 1) state_d = lobm_pkg::S_DEL_RD;
				else state_d = lobm_pkg::S_M_UPS;
			end
			lobm_pkg::S_M_UPS: begin
				if (sq == fq && int'(ns) > 1) state_d = lobm_pkg::S_DEL_RD;
				else state_d = lobm_pkg::S_M_TEST;
			end
			lobm_pkg::S_M_FIN:    if (out_free) state_d = lobm_pkg::S_IDLE;
			default:              state_d = lobm_pkg::S_IDLE;
		endcase
	end

	// memory and result controls
	always_comb begin
		s_tready   = (state_q == lobm_pkg::S_IDLE);
		mem_we     = 1'b0;
		mem_waddr  = addr_of(sym_q, side_q, int'(j_q));
		mem_wdata  = new_entry;
		mem_raddr  = addr_of(sym_q, side_q, int'(j_q));
		out_load   = 1'b0;
		out_last   = 1'b1;
		out_data   = '0;
		out_status = res_status_q;
		unique case (state_q)
			lobm_pkg::S_DISPATCH: begin
				if (!sym_bad && req_q == lobm_pkg::REQ_ADD && !price_bad && !qty_bad
					&& n_req == '0) begin
					mem_we    = 1'b1;
					mem_waddr = addr_of(sym_q, side_q, 0);
				end
			end
			lobm_pkg::S_ADD_WR: begin
				mem_we    = 1'b1;
				mem_waddr = addr_of(sym_q, side_q, int'(j_q) + 1);
				mem_wdata = stays ? new_entry : rdata_q;
			end
			lobm_pkg::S_ADD_HEAD: begin
				mem_we    = 1'b1;
				mem_waddr = addr_of(sym_q, side_q, 0);
			end
			lobm_pkg::S_FIND_CK: begin
				if (hit && req_q == lobm_pkg::REQ_CHANGE) begin
					mem_we    = 1'b1;
					mem_wdata = {e_trader, e_price, QTY_BITS'(nqty_q)};
				end
			end
			lobm_pkg::S_DEL_RD:   mem_raddr = addr_of(sym_q, dside_q, int'(j_q) + 1);
			lobm_pkg::S_DEL_WR: begin
				mem_we    = 1'b1;
				mem_waddr = addr_of(sym_q, dside_q, int'(j_q));
				mem_wdata = rdata_q;
			end
			lobm_pkg::S_RESP:     out_load = out_free;
			lobm_pkg::S_M_RDB:    mem_raddr = addr_of(sym_q, 1'b1, 0);
			lobm_pkg::S_M_RDS:    mem_raddr = addr_of(sym_q, 1'b0, 0);
			lobm_pkg::S_M_CK:     mem_raddr = addr_of(sym_q, 1'b0, 0);
			lobm_pkg::S_M_FILL: begin
				out_load   = pend_v_q && out_free;
				out_last   = 1'b0;
				out_data   = pend_q;
				out_status = lobm_pkg::STAT_FILL;
			end
			lobm_pkg::S_M_UPB: begin
				mem_we    = (bq != fq);
				mem_waddr = addr_of(sym_q, 1'b1, 0);
				mem_wdata = {bh_q[EW-1 -: TW + PRICE_BITS], QTY_BITS'(bq - fq)};
			end
			lobm_pkg::S_M_UPS: begin
				mem_we    = (sq != fq);
				mem_waddr = addr_of(sym_q, 1'b0, 0);
				mem_wdata = {sh_q[EW-1 -: TW + PRICE_BITS], QTY_BITS'(sq - fq)};
			end
			lobm_pkg::S_M_FIN: begin
				out_load   = out_free;
				out_data   = pend_v_q ? pend_q : '0;
				out_status = pend_v_q ? lobm_pkg::STAT_FILL : lobm_pkg::STAT_DONE;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		rdata_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= lobm_pkg::S_IDLE;
			m_tvalid_q <= 1'b0;
			pend_v_q   <= 1'b0;
			fills_q    <= '0;
			for (int k = 0; k < CNT_N; k++) cnt_q[k] <= '0;
		end else begin
			state_q <= state_d;
			if (out_load) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
			unique case (state_q)
				lobm_pkg::S_IDLE: begin
					pend_v_q <= 1'b0;
					fills_q  <= '0;
				end
				lobm_pkg::S_DISPATCH: begin
					if (!sym_bad && req_q == lobm_pkg::REQ_ADD && !price_bad && !qty_bad
						&& n_req == '0)
						cnt_q[ci_of(sym_q, side_q)] <= CW'(1);
				end
				lobm_pkg::S_ADD_WR:
					if (stays) cnt_q[ci_of(sym_q, side_q)] <= n_req + CW'(1);
				lobm_pkg::S_ADD_HEAD: cnt_q[ci_of(sym_q, side_q)] <= n_req + CW'(1);
				lobm_pkg::S_FIND_CK:
					if (hit && req_q == lobm_pkg::REQ_CANCEL && !del_go)
						cnt_q[ci_of(sym_q, dside_q)] <= n_del - CW'(1);
				lobm_pkg::S_DEL_WR:
					if (!more_del) cnt_q[ci_of(sym_q, dside_q)] <= n_del - CW'(1);
				lobm_pkg::S_M_FILL: begin
					if (!pend_v_q || out_free) begin
						pend_v_q <= 1'b1;
						fills_q  <= fills_q + 1'b1;
					end
				end
				lobm_pkg::S_M_UPB:
					if (bq == fq && int'(nb) <= 1) cnt_q[ci_of(sym_q, 1'b1)] <= nb - CW'(1);
				lobm_pkg::S_M_UPS:
					if (sq == fq && int'(ns) <= 1) cnt_q[ci_of(sym_q, 1'b0)] <= ns - CW'(1);
				default: ;
			endcase
		end
	end

	// payload and walk registers
	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= out_data;
			m_tuser_q <= out_status;
			m_tlast_q <= out_last;
		end
		unique case (state_q)
			lobm_pkg::S_IDLE: begin
				if (s_tvalid) begin
					req_q    <= lobm_pkg::req_t'(s_tuser);
					sym_q    <= s_tdata[2:0];
					side_q   <= s_tdata[3];
					trader_q <= s_tdata[13:4];
					price_q  <= s_tdata[33:14];
					qty_q    <= s_tdata[49:34];
					nqty_q   <= s_tdata[65:50];
				end
			end
			lobm_pkg::S_DISPATCH: begin
				dside_q <= side_q;
				dret_q  <= lobm_pkg::S_RESP;
				j_q     <= (req_q == lobm_pkg::REQ_ADD) ? n_req - CW'(1) : '0;
				res_status_q <= lobm_pkg::STAT_DONE;
				if (sym_bad) begin
					res_status_q <= lobm_pkg::STAT_REJECTED;
				end else if (req_q == lobm_pkg::REQ_ADD) begin
					if (price_bad || qty_bad) res_status_q <= lobm_pkg::STAT_REJECTED;
					else if (int'(n_req) >= DEPTH) res_status_q <= lobm_pkg::STAT_FULL;
				end else if (req_q == lobm_pkg::REQ_CHANGE) begin
					if (nqty_bad) res_status_q <= lobm_pkg::STAT_REJECTED;
					else if (n_req == '0) res_status_q <= lobm_pkg::STAT_NOT_FOUND;
				end else if (req_q == lobm_pkg::REQ_CANCEL) begin
					if (n_req == '0) res_status_q <= lobm_pkg::STAT_NOT_FOUND;
				end
			end
			lobm_pkg::S_ADD_WR: if (!stays) j_q <= j_q - CW'(1);
			lobm_pkg::S_FIND_CK: begin
				if (hit) begin
					res_status_q <= lobm_pkg::STAT_DONE;
				end else begin
					j_q <= j_q + CW'(1);
					res_status_q <= lobm_pkg::STAT_NOT_FOUND;
				end
			end
			lobm_pkg::S_DEL_WR:  j_q <= j_q + CW'(1);
			lobm_pkg::S_M_RDS:   bh_q <= rdata_q;
			lobm_pkg::S_M_CK:    sh_q <= rdata_q;
			lobm_pkg::S_M_FILL:  if (!pend_v_q || out_free) pend_q <= fill_word;
			lobm_pkg::S_M_UPB: begin
				dside_q <= 1'b1;
				j_q     <= '0;
				dret_q  <= lobm_pkg::S_M_UPS;
			end
			lobm_pkg::S_M_UPS: begin
				dside_q <= 1'b0;
				j_q     <= '0;
				dret_q  <= lobm_pkg::S_M_TEST;
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_load && m_tvalid_q && !m_tready))
		else $error("result beat overwritten while stalled");
	a_fill_limit: assert property (@(posedge clk) disable iff (!arst_n)
		int'(fills_q) <= lobm_pkg::MAX_FILLS)
		else $error("too many fills in one request");
	a_fill_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && m_tuser_q == lobm_pkg::STAT_FILL) |-> (m_tdata_q[55:40] != '0))
		else $error("fill beat with zero quantity");
	a_side_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lobm_pkg::S_DISPATCH && !sym_bad) |-> (int'(n_req) <= DEPTH))
		else $error("side count above depth");
`endif

endmodule
